/* rtl/tsc_pkg.sv */
// Shared constants and types for the Taylor-series sine, cosine and tangent unit.
`default_nettype none

package tsc_pkg;

  // Series depth: terms 0 to LAST_TERM_INDEX of each series.
  localparam int LAST_TERM_INDEX = 10;
  localparam int NUM_CELLS       = LAST_TERM_INDEX;

  localparam int NUM_LANES = 2;
  localparam int LANE_SIN  = 0;
  localparam int LANE_COS  = 1;
  localparam int LANE_TAN  = 0;
  localparam int LANE_COT  = 1;

  // Internal fixed point: 40 fraction bits.
  localparam int FRAC_BITS   = 40;
  localparam int ANGLE_W     = 32;
  localparam int ANGLE_SHIFT = 12;
  localparam int SQ_SHIFT    = FRAC_BITS - 2 * ANGLE_SHIFT;

  // Series cell datapath widths.
  localparam int X2_W        = 47;
  localparam int H_W         = 54;
  localparam int HMAG_W      = H_W - 1;
  localparam int DIV_W       = 10;
  localparam int RECIP_SHIFT = 47;
  localparam int RECIP_W     = 47;
  localparam int N_LO_W      = 24;
  localparam int DP_W        = 2 * N_LO_W;
  localparam int DA_W        = DP_W + N_LO_W;
  localparam int DPROD_W     = DA_W + N_LO_W;
  localparam int Q_W         = 47;
  localparam int T_W         = X2_W + 1;
  localparam int M_W         = 46;
  localparam int M_LO_W      = 23;
  localparam int H_LO_W      = 27;
  localparam int MP_W        = M_LO_W + H_LO_W;
  localparam int MA_W        = MP_W + M_LO_W + 1;
  localparam int MPROD_W     = MA_W + H_LO_W + 1;
  localparam int SER_STAGES  = 10;

  localparam logic [H_W-1:0] Q_ONE = {{(H_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  // Quotient widths.
  localparam int QUO_W    = 32;
  localparam int Q16_BITS = 16;
  localparam int DEN_W    = QUO_W + 1;
  localparam int NUM_W    = QUO_W + Q16_BITS + 1;
  localparam int DIV_CELLS = QUO_W;

  typedef struct packed {
    logic [X2_W-1:0]    x2;
    logic [ANGLE_W-1:0] amag;
    logic               aneg;
  } side_t;

  typedef struct packed {
    side_t                            side;
    logic [NUM_LANES-1:0][H_W-1:0]    h;
  } series_t;

  typedef struct packed {
    logic [DEN_W-1:0] prem;
    logic [QUO_W-1:0] quo;
    logic [DEN_W-1:0] den;
    logic             ovf;
    logic             zero;
    logic             neg;
    logic             num_neg;
  } div_lane_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]              sine;
    logic [ANGLE_W-1:0]              cosine;
    div_lane_t [NUM_LANES-1:0]       lane;
  } div_word_t;

endpackage

`default_nettype wire

/* rtl/taylor_sine_cosine_tangent.sv */
// Top level of the Taylor-series sine, cosine, tangent and cotangent unit.
//
//  Channel  Handshake           Payload
//  in       in_valid/in_stall   in_angle (Q3.28 radians)
//  out      out_valid/out_stall out_sine_value, out_cosine_value (Q1.30),
//                               out_tangent_value, out_cotangent_value (Q16.16),
//                               out_tangent_saturated, out_cotangent_saturated
//
// One angle is taken every cycle while in_stall is low; each result passes 3 squaring
// stages, the series cells, 5 finishing stages, 32 quotient cells and the output register.
// The latency is set by the series cells and the bit-per-cycle quotient chain.
// Reset clears only the valid bits of the pipeline and the output register.
// While a result waits on out_stall the whole pipeline holds and in_stall is raised.
`default_nettype none

module taylor_sine_cosine_tangent
  import tsc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [ANGLE_W-1:0] in_angle,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [ANGLE_W-1:0]      out_sine_value,
  output logic signed [ANGLE_W-1:0]      out_cosine_value,
  output logic signed [ANGLE_W-1:0]      out_tangent_value,
  output logic signed [ANGLE_W-1:0]      out_cotangent_value,
  output logic                           out_tangent_saturated,
  output logic                           out_cotangent_saturated
);

  localparam int SQ_W    = 2 * ANGLE_W;
  localparam int SP_LO_W = ANGLE_W + H_LO_W;
  localparam int SPROD_W = ANGLE_W + HMAG_W + 1;
  localparam int SP_SHIFT = FRAC_BITS - ANGLE_SHIFT;
  localparam int SMAG_W  = SPROD_W - SP_SHIFT;
  localparam logic [ANGLE_W-1:0] SAT_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic [ANGLE_W-1:0] SAT_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

  // Magnitude to Q1.30, rounded half away from zero, sign restored and clipped.
  function automatic logic [ANGLE_W-1:0] sat_q30(input logic [SMAG_W-1:0] mag,
                                                 input logic neg);
    logic [SMAG_W:0]    sum;
    logic [SMAG_W-10:0] q;
    sum = {1'b0, mag} + (SMAG_W'(1) << 9);
    q = sum[10 +: SMAG_W-9];
    if (neg) begin
      sat_q30 = (q >= (SMAG_W-9)'(SAT_MIN)) ? SAT_MIN : ANGLE_W'(-q);
    end else begin
      sat_q30 = (q > (SMAG_W-9)'(SAT_MAX)) ? SAT_MAX : ANGLE_W'(q);
    end
  endfunction

  function automatic div_lane_t div_setup(input logic [ANGLE_W-1:0] num,
                                          input logic [ANGLE_W-1:0] dvs);
    logic [ANGLE_W-1:0] nm;
    logic [ANGLE_W-1:0] dm;
    logic [NUM_W-1:0]   wide;
    div_lane_t          w;
    nm = num[ANGLE_W-1] ? -num : num;
    dm = dvs[ANGLE_W-1] ? -dvs : dvs;
    // Rounded quotient: (2 * n * 2^16 + d) / (2 * d).
    wide = (NUM_W'(nm) << (Q16_BITS + 1)) + NUM_W'(dm);
    w.den     = {dm, 1'b0};
    w.prem    = DEN_W'(wide[NUM_W-1:QUO_W]);
    w.quo     = wide[QUO_W-1:0];
    w.ovf     = DEN_W'(wide[NUM_W-1:QUO_W]) >= w.den;
    w.zero    = (dvs == '0);
    w.neg     = num[ANGLE_W-1] ^ dvs[ANGLE_W-1];
    w.num_neg = num[ANGLE_W-1];
    return w;
  endfunction

  // Returns the saturation flag above the Q16.16 value.
  function automatic logic [ANGLE_W:0] div_finish(input div_lane_t w);
    if (w.zero) begin
      div_finish = {1'b1, w.num_neg ? SAT_MIN : SAT_MAX};
    end else if (w.neg) begin
      if (w.ovf || (w.quo[QUO_W-1] && (w.quo[QUO_W-2:0] != '0))) begin
        div_finish = {1'b1, SAT_MIN};
      end else begin
        div_finish = {1'b0, ANGLE_W'(-w.quo)};
      end
    end else if (w.ovf || w.quo[QUO_W-1]) begin
      div_finish = {1'b1, SAT_MAX};
    end else begin
      div_finish = {1'b0, w.quo};
    end
  endfunction

  logic en;

  // Squaring front end.
  logic [2:0]          fv_r;
  logic [ANGLE_W-1:0]  a1_r, a2_r, a3_r;
  logic                s1_r, s2_r, s3_r;
  logic [SQ_W-1:0]     sq2_r;
  logic [X2_W-1:0]     x3_r;
  logic [ANGLE_W-1:0]  amag_nxt;
  logic [SQ_W-1:0]     sq_round_nxt;

  // Series chain.
  series_t               ser_data  [NUM_CELLS+1];
  logic [NUM_CELLS:0]    ser_valid;

  // Finishing stages.
  logic [3:0]          ev_r;
  logic [HMAG_W-1:0]   hsm_r, hcm_r;
  logic                hsn_r, hcn_r;
  logic [ANGLE_W-1:0]  ea1_r;
  logic                en1_r, en2_r;
  logic [SP_LO_W-1:0]  sp0_r, sp1_r;
  logic                hsn2_r;
  logic [ANGLE_W-1:0]  c2_r, c3_r, c4_r, s4_r;
  logic [SMAG_W-1:0]   sm3_r;
  logic                sn3_r;
  logic [SPROD_W-1:0]  sprod_nxt;
  logic [H_W-1:0]      hs_last, hc_last;

  // Quotient chain.
  div_word_t             div_data  [DIV_CELLS+1];
  logic [DIV_CELLS:0]    div_valid;
  div_word_t             div0_r;
  logic                  dv_r;

  // Output register.
  logic                 out_valid_r;
  logic [ANGLE_W-1:0]   out_sin_r, out_cos_r, out_tan_r, out_cot_r;
  logic                 out_tan_sat_r, out_cot_sat_r;
  logic [ANGLE_W:0]     tan_nxt, cot_nxt;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign amag_nxt     = in_angle[ANGLE_W-1] ? ANGLE_W'(-in_angle) : ANGLE_W'(in_angle);
  assign sq_round_nxt = sq2_r + (SQ_W'(1) << (SQ_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= amag_nxt;
      s1_r  <= in_angle[ANGLE_W-1];
      sq2_r <= SQ_W'(a1_r) * SQ_W'(a1_r);
      a2_r  <= a1_r;
      s2_r  <= s1_r;
      x3_r  <= sq_round_nxt[SQ_SHIFT +: X2_W];
      a3_r  <= a2_r;
      s3_r  <= s2_r;
    end
  end

  assign ser_valid[0] = fv_r[2];
  assign ser_data[0]  = '{side: '{x2: x3_r, amag: a3_r, aneg: s3_r},
                          h: {NUM_LANES{Q_ONE}}};

  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_ser
    localparam int K = LAST_TERM_INDEX - j;
    localparam int D_SIN = 2 * K * (2 * K + 1);
    localparam int D_COS = (2 * K - 1) * (2 * K);
    localparam logic [RECIP_W-1:0] R_SIN = RECIP_W'((64'd1 << RECIP_SHIFT) / D_SIN);
    localparam logic [RECIP_W-1:0] R_COS = RECIP_W'((64'd1 << RECIP_SHIFT) / D_COS);

    tsc_series_cell u_ser (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (ser_valid[j]),
      .in_data   (ser_data[j]),
      .divisor   ({DIV_W'(D_COS), DIV_W'(D_SIN)}),
      .recip     ({R_COS, R_SIN}),
      .out_valid (ser_valid[j+1]),
      .out_data  (ser_data[j+1])
    );
  end

  assign hs_last   = ser_data[NUM_CELLS].h[LANE_SIN];
  assign hc_last   = ser_data[NUM_CELLS].h[LANE_COS];
  assign sprod_nxt = SPROD_W'(sp0_r) + (SPROD_W'(sp1_r) << H_LO_W)
                     + (SPROD_W'(1) << (SP_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= '0;
      dv_r <= 1'b0;
    end else if (en) begin
      ev_r <= {ev_r[2:0], ser_valid[NUM_CELLS]};
      dv_r <= ev_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hsm_r  <= hs_last[H_W-1] ? HMAG_W'(-hs_last) : HMAG_W'(hs_last);
      hsn_r  <= hs_last[H_W-1];
      hcm_r  <= hc_last[H_W-1] ? HMAG_W'(-hc_last) : HMAG_W'(hc_last);
      hcn_r  <= hc_last[H_W-1];
      ea1_r  <= ser_data[NUM_CELLS].side.amag;
      en1_r  <= ser_data[NUM_CELLS].side.aneg;
      sp0_r  <= SP_LO_W'(ea1_r) * SP_LO_W'(hsm_r[H_LO_W-1:0]);
      sp1_r  <= SP_LO_W'(ea1_r) * SP_LO_W'(hsm_r[HMAG_W-1:H_LO_W]);
      en2_r  <= en1_r;
      hsn2_r <= hsn_r;
      c2_r   <= sat_q30(SMAG_W'(hcm_r), hcn_r);
      sm3_r  <= sprod_nxt[SP_SHIFT +: SMAG_W];
      sn3_r  <= en2_r ^ hsn2_r;
      c3_r   <= c2_r;
      s4_r   <= sat_q30(sm3_r, sn3_r);
      c4_r   <= c3_r;
      div0_r.sine           <= s4_r;
      div0_r.cosine         <= c4_r;
      div0_r.lane[LANE_TAN] <= div_setup(s4_r, c4_r);
      div0_r.lane[LANE_COT] <= div_setup(c4_r, s4_r);
    end
  end

  assign div_valid[0] = dv_r;
  assign div_data[0]  = div0_r;

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    tsc_div_cell u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (div_valid[j]),
      .in_data   (div_data[j]),
      .out_valid (div_valid[j+1]),
      .out_data  (div_data[j+1])
    );
  end

  assign tan_nxt = div_finish(div_data[DIV_CELLS].lane[LANE_TAN]);
  assign cot_nxt = div_finish(div_data[DIV_CELLS].lane[LANE_COT]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_valid[DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sin_r     <= div_data[DIV_CELLS].sine;
      out_cos_r     <= div_data[DIV_CELLS].cosine;
      out_tan_r     <= tan_nxt[ANGLE_W-1:0];
      out_tan_sat_r <= tan_nxt[ANGLE_W];
      out_cot_r     <= cot_nxt[ANGLE_W-1:0];
      out_cot_sat_r <= cot_nxt[ANGLE_W];
    end
  end

  assign out_valid               = out_valid_r;
  assign out_sine_value          = out_sin_r;
  assign out_cosine_value        = out_cos_r;
  assign out_tangent_value       = out_tan_r;
  assign out_cotangent_value     = out_cot_r;
  assign out_tangent_saturated   = out_tan_sat_r;
  assign out_cotangent_saturated = out_cot_sat_r;

  // A zero divisor must always raise the matching flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_cos_r == '0) |-> out_tan_sat_r)
    else $error("tangent flag missing for zero cosine");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_sin_r == '0) |-> out_cot_sat_r)
    else $error("cotangent flag missing for zero sine");

  // With both operands non-negative a clipped tangent can only be the positive limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tan_sat_r && !out_sin_r[ANGLE_W-1] && !out_cos_r[ANGLE_W-1]
    |-> out_tan_r == SAT_MAX)
    else $error("tangent clipped to the wrong limit");

endmodule

`default_nettype wire

/* rtl/tsc_series_cell.sv */
// One Horner level of the sine and cosine series: h becomes 1 - round(x2 / d) * h.
`default_nettype none

module tsc_series_cell
  import tsc_pkg::*;
(
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                en,
  input  wire logic                                in_valid,
  input  wire series_t                             in_data,
  input  wire logic [NUM_LANES-1:0][DIV_W-1:0]     divisor,
  input  wire logic [NUM_LANES-1:0][RECIP_W-1:0]   recip,
  output logic                                     out_valid,
  output series_t                                  out_data
);

  logic [SER_STAGES-1:0] vld_r;
  side_t                 side_r [SER_STAGES];

  logic [X2_W-1:0]    n_r   [NUM_LANES][5];
  logic [HMAG_W-1:0]  hm_r  [NUM_LANES][6];
  logic               hn_r  [NUM_LANES][9];
  logic [DP_W-1:0]    dp_r  [NUM_LANES][4];
  logic [DA_W-1:0]    da_r  [NUM_LANES];
  logic [DA_W-1:0]    db_r  [NUM_LANES];
  logic [Q_W-1:0]     q_r   [NUM_LANES][2];
  logic [T_W-1:0]     t_r   [NUM_LANES];
  logic [M_W-1:0]     m_r   [NUM_LANES];
  logic [MP_W-1:0]    mp_r  [NUM_LANES][4];
  logic [MA_W-1:0]    ma_r  [NUM_LANES];
  logic [MA_W-1:0]    mb_r  [NUM_LANES];
  logic [HMAG_W-1:0]  r_r   [NUM_LANES];
  logic [H_W-1:0]     h_r   [NUM_LANES];

  logic [HMAG_W-1:0]  habs_nxt  [NUM_LANES];
  logic [T_W-1:0]     rem_nxt   [NUM_LANES];
  logic [M_W-1:0]     m_nxt     [NUM_LANES];
  logic [DPROD_W-1:0] dprod_nxt [NUM_LANES];
  logic [MPROD_W-1:0] mprod_nxt [NUM_LANES];
  logic [H_W-1:0]     h_nxt     [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      habs_nxt[l] = in_data.h[l][H_W-1] ? HMAG_W'(-in_data.h[l]) : HMAG_W'(in_data.h[l]);
      dprod_nxt[l] = DPROD_W'(da_r[l]) + (DPROD_W'(db_r[l]) << N_LO_W);
      // The reciprocal estimate is low by at most one; the remainder corrects it.
      rem_nxt[l] = {1'b0, n_r[l][4]} - t_r[l];
      m_nxt[l] = (rem_nxt[l] >= T_W'(divisor[l])) ? M_W'(q_r[l][1]) + M_W'(1)
                                                   : M_W'(q_r[l][1]);
      mprod_nxt[l] = MPROD_W'(ma_r[l]) + (MPROD_W'(mb_r[l]) << H_LO_W)
                     + (MPROD_W'(1) << (FRAC_BITS - 1));
      h_nxt[l] = hn_r[l][8] ? Q_ONE + H_W'(r_r[l]) : Q_ONE - H_W'(r_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SER_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_data.side;
      for (int i = 1; i < SER_STAGES; i++) begin
        side_r[i] <= side_r[i-1];
      end
      for (int l = 0; l < NUM_LANES; l++) begin
        n_r[l][0] <= in_data.side.x2 + X2_W'(divisor[l] >> 1);
        for (int i = 1; i < 5; i++) begin
          n_r[l][i] <= n_r[l][i-1];
        end
        hm_r[l][0] <= habs_nxt[l];
        for (int i = 1; i < 6; i++) begin
          hm_r[l][i] <= hm_r[l][i-1];
        end
        hn_r[l][0] <= in_data.h[l][H_W-1];
        for (int i = 1; i < 9; i++) begin
          hn_r[l][i] <= hn_r[l][i-1];
        end
        dp_r[l][0] <= DP_W'(n_r[l][0][N_LO_W-1:0]) * DP_W'(recip[l][N_LO_W-1:0]);
        dp_r[l][1] <= DP_W'(n_r[l][0][N_LO_W-1:0]) * DP_W'(recip[l][RECIP_W-1:N_LO_W]);
        dp_r[l][2] <= DP_W'(n_r[l][0][X2_W-1:N_LO_W]) * DP_W'(recip[l][N_LO_W-1:0]);
        dp_r[l][3] <= DP_W'(n_r[l][0][X2_W-1:N_LO_W]) * DP_W'(recip[l][RECIP_W-1:N_LO_W]);
        da_r[l] <= DA_W'(dp_r[l][0]) + (DA_W'(dp_r[l][1]) << N_LO_W);
        db_r[l] <= DA_W'(dp_r[l][2]) + (DA_W'(dp_r[l][3]) << N_LO_W);
        q_r[l][0] <= dprod_nxt[l][RECIP_SHIFT +: Q_W];
        q_r[l][1] <= q_r[l][0];
        t_r[l] <= T_W'(q_r[l][0]) * T_W'(divisor[l]);
        m_r[l] <= m_nxt[l];
        mp_r[l][0] <= MP_W'(m_r[l][M_LO_W-1:0]) * MP_W'(hm_r[l][5][H_LO_W-1:0]);
        mp_r[l][1] <= MP_W'(m_r[l][M_LO_W-1:0]) * MP_W'(hm_r[l][5][HMAG_W-1:H_LO_W]);
        mp_r[l][2] <= MP_W'(m_r[l][M_W-1:M_LO_W]) * MP_W'(hm_r[l][5][H_LO_W-1:0]);
        mp_r[l][3] <= MP_W'(m_r[l][M_W-1:M_LO_W]) * MP_W'(hm_r[l][5][HMAG_W-1:H_LO_W]);
        ma_r[l] <= MA_W'(mp_r[l][0]) + (MA_W'(mp_r[l][2]) << M_LO_W);
        mb_r[l] <= MA_W'(mp_r[l][1]) + (MA_W'(mp_r[l][3]) << M_LO_W);
        r_r[l] <= mprod_nxt[l][FRAC_BITS +: HMAG_W];
        h_r[l] <= h_nxt[l];
      end
    end
  end

  assign out_valid = vld_r[SER_STAGES-1];
  always_comb begin
    out_data.side = side_r[SER_STAGES-1];
    for (int l = 0; l < NUM_LANES; l++) begin
      out_data.h[l] = h_r[l];
    end
  end

endmodule

`default_nettype wire

/* rtl/tsc_div_cell.sv */
// One restoring step of the tangent and cotangent quotients: one quotient bit per lane.
`default_nettype none

module tsc_div_cell
  import tsc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire logic      in_valid,
  input  wire div_word_t in_data,
  output logic           out_valid,
  output div_word_t      out_data
);

  logic      vld_r;
  div_word_t word_r;
  div_word_t word_nxt;
  logic [DEN_W:0] trial [NUM_LANES];
  logic           ge    [NUM_LANES];

  always_comb begin
    word_nxt = in_data;
    for (int l = 0; l < NUM_LANES; l++) begin
      // Shift the next numerator bit into the partial remainder.
      trial[l] = {in_data.lane[l].prem, in_data.lane[l].quo[QUO_W-1]};
      ge[l]    = trial[l] >= {1'b0, in_data.lane[l].den};
      word_nxt.lane[l].prem = ge[l] ? DEN_W'(trial[l] - {1'b0, in_data.lane[l].den})
                                    : trial[l][DEN_W-1:0];
      word_nxt.lane[l].quo  = {in_data.lane[l].quo[QUO_W-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = word_r;

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the Taylor-series sine, cosine, tangent and cotangent unit.
`timescale 1ns / 100ps

module testbench;
  import tsc_pkg::*;

  typedef struct packed {
    logic [31:0] sine;
    logic [31:0] cosine;
    logic [31:0] tangent;
    logic [31:0] cotangent;
    logic        tan_sat;
    logic        cot_sat;
  } trig_t;

  typedef struct {
    logic [31:0] angle;
    bit          typed;
    trig_t       res;
  } row_t;

  localparam logic [63:0] INT64_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ONE_Q40 = 64'sd1 <<< 40;
  localparam int ANGLE_LIMIT = 1686629713;
  localparam int NUM_RANDOM = 2000;
  localparam int TAIL_CYCLES = 300;
  localparam int NUM_DIRECTED = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_angle = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_sine_value, out_cosine_value, out_tangent_value, out_cotangent_value;
  logic        out_tangent_saturated, out_cotangent_saturated;

  trig_t expected_q[$];
  row_t  pending_rows[$];
  int    mismatches = 0;
  bit    stimulus_done = 1'b0;
  int    accepted = 0;

  taylor_sine_cosine_tangent DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_angle(in_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sine_value(out_sine_value), .out_cosine_value(out_cosine_value),
    .out_tangent_value(out_tangent_value), .out_cotangent_value(out_cotangent_value),
    .out_tangent_saturated(out_tangent_saturated),
    .out_cotangent_saturated(out_cotangent_saturated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] magnitude(logic signed [63:0] v);
    return v < 0 ? 64'd0 - v : v;
  endfunction

  // Rounded Q.40 product of two magnitudes, capped at the largest signed 64-bit value.
  function automatic logic [63:0] mul_mag_q40(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    logic [63:0]  r;
    p = {64'd0, a} * {64'd0, b} + (128'd1 << 39);
    if (p[127:104] != 0) return INT64_TOP;
    r = p[103:40];
    if (r[63]) r = INT64_TOP;
    return r;
  endfunction

  function automatic logic signed [63:0] mul_q40(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] r;
    r = mul_mag_q40(magnitude(a), magnitude(b));
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic logic signed [63:0] horner_series(logic signed [63:0] x2, bit odd);
    logic signed [63:0] h;
    logic [63:0] d, m;
    h = ONE_Q40;
    for (int k = LAST_TERM_INDEX; k >= 1; k--) begin
      d = odd ? 64'(2 * k) * 64'(2 * k + 1) : 64'(2 * k - 1) * 64'(2 * k);
      m = (64'(x2) + d / 2) / d;
      h = ONE_Q40 - mul_q40(m, h);
    end
    return h;
  endfunction

  function automatic logic [31:0] q40_to_q30(logic signed [63:0] v);
    logic [63:0] q;
    q = (magnitude(v) + (64'd1 << 9)) >> 10;
    if (v < 0) return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q);
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  function automatic logic [32:0] ratio_q16(logic signed [31:0] n, logic signed [31:0] d);
    logic [63:0] nm, dm, q;
    if (d == 0) return {1'b1, (n < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF};
    nm = magnitude(64'(n)) << 16;
    dm = magnitude(64'(d));
    q = (2 * nm + dm) / (2 * dm);
    if ((n < 0) != (d < 0)) begin
      if (q > 64'h8000_0000) return {1'b1, 32'h8000_0000};
      return {1'b0, 32'(64'd0 - q)};
    end
    if (q > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, q[31:0]};
  endfunction

  function automatic trig_t predict_trig(logic [31:0] angle);
    logic signed [63:0] x, x2;
    logic [32:0] tn, ct;
    trig_t r;
    x = 64'($signed(angle)) * 4096;
    x2 = mul_q40(x, x);
    r.sine = q40_to_q30(mul_q40(x, horner_series(x2, 1'b1)));
    r.cosine = q40_to_q30(horner_series(x2, 1'b0));
    tn = ratio_q16(r.sine, r.cosine);
    ct = ratio_q16(r.cosine, r.sine);
    r.tangent = tn[31:0];
    r.tan_sat = tn[32];
    r.cotangent = ct[31:0];
    r.cot_sat = ct[32];
    return r;
  endfunction

  // Expectations are formed at the input transaction and compared at the output transaction.
  always @(posedge clk) begin
    trig_t got, want;
    row_t  row;
    if (rst_n && in_valid && !in_stall) begin
      row = pending_rows.pop_front();
      expected_q.push_back(row.typed ? row.res : predict_trig(in_angle));
      accepted++;
    end
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_sine_value, out_cosine_value, out_tangent_value, out_cotangent_value,
              out_tangent_saturated, out_cotangent_saturated};
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction");
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (got.sine !== want.sine) begin
          $error("sine_value expected %h got %h", want.sine, got.sine); mismatches++;
        end
        if (got.cosine !== want.cosine) begin
          $error("cosine_value expected %h got %h", want.cosine, got.cosine); mismatches++;
        end
        if (got.tangent !== want.tangent) begin
          $error("tangent_value expected %h got %h", want.tangent, got.tangent); mismatches++;
        end
        if (got.cotangent !== want.cotangent) begin
          $error("cotangent_value expected %h got %h", want.cotangent, got.cotangent);
          mismatches++;
        end
        if (got.tan_sat !== want.tan_sat) begin
          $error("tangent_saturated expected %b got %b", want.tan_sat, got.tan_sat);
          mismatches++;
        end
        if (got.cot_sat !== want.cot_sat) begin
          $error("cotangent_saturated expected %b got %b", want.cot_sat, got.cot_sat);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random stall patterns, plus one long hold-off that fills the pipeline.
  initial begin
    int  seg, mode;
    bit  long_done;
    long_done = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!long_done && accepted > 300) begin
        long_done = 1'b1;
        out_stall = 1'b1;
        for (int c = 0; c < 600; c++) @(negedge clk);
      end
      seg = $urandom_range(5, 60);
      mode = $urandom_range(0, 3);
      for (int c = 0; c < seg; c++) begin
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          2: out_stall = ($urandom_range(0, 1) == 0);
          default: out_stall = ($urandom_range(0, 3) != 0);
        endcase
        if (c != seg - 1) @(negedge clk);
      end
    end
  end

  // Sends one row, holding the payload steady until the transaction completes.
  task automatic offer_row(row_t row);
    pending_rows.push_back(row);
    in_angle = row.angle;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    row_t  table_rows[$];
    row_t  row;
    int    burst, gap;
    logic [31:0] directed_angles [NUM_DIRECTED] = '{
      32'd0, ANGLE_LIMIT, -ANGLE_LIMIT, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
      32'd421657428, -32'd421657428, 32'd843314857, -32'd843314857, 32'd1264972285,
      32'd268435456, -32'd268435456, 32'd210828714, 32'h5555_5555, 32'hAAAA_AAAA,
      32'h0000_FFFF, 32'hFFFF_0000, 32'd1073741824};
    foreach (directed_angles[i]) begin
      row.angle = directed_angles[i];
      row.typed = 1'b0;
      row.res = '0;
      // A zero angle gives zero sine, unit cosine and a clipped cotangent.
      if (directed_angles[i] == 0) begin
        row.typed = 1'b1;
        row.res = '{32'd0, 32'h4000_0000, 32'd0, 32'h7FFF_FFFF, 1'b0, 1'b1};
      end
      table_rows.push_back(row);
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (table_rows[i]) offer_row(table_rows[i]);
    in_valid = 1'b0;
    row.typed = 1'b0;
    for (int n = 0; n < NUM_RANDOM; n += burst) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++) begin
        if ($urandom_range(0, 9) == 0) row.angle = $urandom;
        else row.angle = $urandom_range(0, 2 * ANGLE_LIMIT) - ANGLE_LIMIT;
        offer_row(row);
      end
      in_valid = 1'b0;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      for (int g = 0; g < gap; g++) @(negedge clk);
    end
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
rtl/tsc_pkg.sv
rtl/tsc_series_cell.sv
rtl/tsc_div_cell.sv
rtl/taylor_sine_cosine_tangent.sv
bench/testbench.sv
